/* sv/tfcr_pkg.sv */
// ----------------------------------------------------------------------------
// tfcr_pkg
// Shared types and constants for the tail framed command receiver.
// ----------------------------------------------------------------------------
package tfcr_pkg;

    localparam int OVERRUN_LIMIT_DEF = 64;
    localparam int FRAME_KEEP        = 11;
    localparam int IDX_W             = $clog2(FRAME_KEEP);
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int S_TDATA_W         = 8;
    localparam int M_TDATA_W         = 72;

    localparam logic [7:0] TAIL_FIRST  = 8'hED;
    localparam logic [7:0] TAIL_SECOND = 8'hDE;
    localparam logic [7:0] HEAD_FIRST  = 8'hFE;
    localparam logic [7:0] HEAD_SECOND = 8'hEF;
    localparam logic [7:0] CLASS_MASK  = 8'hF0;
    localparam logic [7:0] SLOT_MASK   = 8'h0F;

    localparam logic [3:0] SLIDER_SLOTS = 4'd7;
    localparam logic [3:0] BUTTON_SLOTS = 4'd8;
    localparam logic [3:0] KEY_SLOTS    = 4'd4;
    localparam logic [3:0] STICK_SLOTS  = 4'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CLS_SLIDER = 2'd0,
        CLS_BUTTON = 2'd1,
        CLS_KEY    = 2'd2,
        CLS_STICK  = 2'd3
    } t_cmd_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLIDER_EN = 3'd0,
        REG_BUTTON_EN = 3'd1,
        REG_KEY_EN    = 3'd2,
        REG_STICK_EN  = 3'd3,
        REG_TIMEOUT   = 3'd4
    } t_cfg_index;

    typedef logic [FRAME_KEEP-1:0][7:0] t_frame;

    typedef struct packed {
        logic [6:0] slider;
        logic [7:0] button;
        logic [3:0] key;
        logic [1:0] stick;
    } t_enables;

    // buffer as seen right after the current byte, and whether it closed a frame
    typedef struct packed {
        t_frame frame;
        logic   frame_end;
    } t_frame_view;

    typedef struct packed {
        t_cmd_class  cmd_class;
        logic [3:0]  cmd_slot;
        logic [31:0] value_x;
        logic [31:0] value_y;
    } t_result;

endpackage

/* sv/tfcr_rx_state.sv */
// ----------------------------------------------------------------------------
// tfcr_rx_state
// Receive buffer, byte count, tail detection and idle timeout.
// ----------------------------------------------------------------------------
module tfcr_rx_state #(
    parameter int OVERRUN_LIMIT = tfcr_pkg::OVERRUN_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  tfcr_pkg::t_kind       i_kind,
    input  logic [7:0]            i_byte,
    input  logic [15:0]           i_reload,
    output tfcr_pkg::t_frame_view o_view
);

    localparam int CNT_W = $clog2(OVERRUN_LIMIT + 2);

    tfcr_pkg::t_frame r_frame, n_frame, w_frame;
    logic [CNT_W-1:0] r_count, n_count, w_count_inc;
    logic [7:0]       r_prev, n_prev;
    logic [15:0]      r_idle, n_idle;
    logic             w_end;

    always_comb begin
        w_frame     = r_frame;
        w_count_inc = r_count + 1'b1;
        if (r_count < CNT_W'(tfcr_pkg::FRAME_KEEP)) begin
            w_frame[r_count[tfcr_pkg::IDX_W-1:0]] = i_byte;
        end
        w_end = (r_prev == tfcr_pkg::TAIL_FIRST) && (i_byte == tfcr_pkg::TAIL_SECOND);
    end

    assign o_view.frame     = w_frame;
    assign o_view.frame_end = w_end && (i_kind == tfcr_pkg::KIND_BYTE);

    always_comb begin
        n_frame = r_frame;
        n_count = r_count;
        n_prev  = r_prev;
        n_idle  = r_idle;
        if (i_step) begin
            unique case (i_kind)
                tfcr_pkg::KIND_TICK: begin
                    if (r_idle == '0) begin
                        n_frame = '0;
                        n_count = '0;
                        n_prev  = '0;
                    end else begin
                        n_idle = r_idle - 1'b1;
                    end
                end
                tfcr_pkg::KIND_BYTE: begin
                    n_frame = w_frame;
                    n_idle  = i_reload;
                    n_prev  = i_byte;
                    if (w_end) begin
                        n_count = '0;
                    end else if (w_count_inc > CNT_W'(OVERRUN_LIMIT)) begin
                        // overrun wipes the buffer
                        n_frame = '0;
                        n_count = '0;
                        n_prev  = '0;
                    end else begin
                        n_count = w_count_inc;
                    end
                end
                default: begin
                    n_idle = r_idle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_count <= '0;
            r_prev  <= '0;
            r_idle  <= '0;
        end else begin
            r_frame <= n_frame;
            r_count <= n_count;
            r_prev  <= n_prev;
            r_idle  <= n_idle;
        end
    end

endmodule

/* sv/tfcr_decode.sv */
// ----------------------------------------------------------------------------
// tfcr_decode
// Header check, class and slot split, enable lookup and payload words.
// ----------------------------------------------------------------------------
module tfcr_decode (
    input  tfcr_pkg::t_frame_view i_view,
    input  tfcr_pkg::t_enables    i_enables,
    output logic                  o_hit,
    output tfcr_pkg::t_result     o_result
);

    tfcr_pkg::t_frame f;
    logic [3:0]       w_cls;
    logic [3:0]       w_slot;
    logic [3:0]       w_slot_m1;
    logic [3:0]       w_slots;
    logic [7:0]       w_mask;
    logic             w_cls_ok;
    logic             w_header;

    assign f = i_view.frame;

    always_comb begin
        w_cls     = 4'((f[2] & tfcr_pkg::CLASS_MASK) >> 4);
        w_slot    = 4'(f[2] & tfcr_pkg::SLOT_MASK);
        w_slot_m1 = w_slot - 1'b1;
        w_header  = (f[0] == tfcr_pkg::HEAD_FIRST) && (f[1] == tfcr_pkg::HEAD_SECOND);
        w_cls_ok  = 1'b1;
        unique case (w_cls)
            4'(tfcr_pkg::CLS_SLIDER): begin
                w_mask  = {1'b0, i_enables.slider};
                w_slots = tfcr_pkg::SLIDER_SLOTS;
            end
            4'(tfcr_pkg::CLS_BUTTON): begin
                w_mask  = i_enables.button;
                w_slots = tfcr_pkg::BUTTON_SLOTS;
            end
            4'(tfcr_pkg::CLS_KEY): begin
                w_mask  = {4'b0, i_enables.key};
                w_slots = tfcr_pkg::KEY_SLOTS;
            end
            4'(tfcr_pkg::CLS_STICK): begin
                w_mask  = {6'b0, i_enables.stick};
                w_slots = tfcr_pkg::STICK_SLOTS;
            end
            default: begin
                w_mask   = '0;
                w_slots  = '0;
                w_cls_ok = 1'b0;
            end
        endcase
        o_hit = i_view.frame_end && w_header && w_cls_ok
             && (w_slot != '0) && (w_slot <= w_slots) && w_mask[w_slot_m1[2:0]];

        o_result.cmd_class = tfcr_pkg::t_cmd_class'(w_cls[1:0]);
        o_result.cmd_slot  = w_slot;
        o_result.value_x   = {f[6], f[5], f[4], f[3]};
        o_result.value_y   = (w_cls[1:0] == tfcr_pkg::CLS_STICK) ? {f[10], f[9], f[8], f[7]}
                                                                 : 32'd0;
    end

endmodule

/* sv/tail_framed_command_receiver.sv */
// ----------------------------------------------------------------------------
// tail_framed_command_receiver
// Serial command frame receiver: header FE EF, tail ED DE, idle timeout.
// ----------------------------------------------------------------------------
// Takes one item per clock, either a received byte (tuser 0) or a timeout
// tick (tuser 1), and keeps that rate as long as the result side takes its
// items. An item goes into an input register; when the work stage moves,
// it updates the frame buffer, count and idle counter, decodes a completed
// frame and puts the result into the output register, from which a command
// is offered on the result side. Frames are dropped without a result when
// the header is missing or the class, slot or slot enable does not match.
// Configuration writes are taken at any time but belong to idle periods.
module tail_framed_command_receiver #(
    parameter int OVERRUN_LIMIT = tfcr_pkg::OVERRUN_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [tfcr_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [7:0] rx_byte
    input  logic                             i_s_tuser,  // [0] kind
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] cmd_slot, [35:4] value_x, [67:36] value_y, [71:68] zero
    output logic [tfcr_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [1:0]                       o_m_tuser,  // [1:0] cmd_class
    input  logic                             i_cfg_we,
    input  logic [tfcr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfcr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tfcr_pkg::t_enables    r_en;
    logic [15:0]           r_reload;
    logic                  r_in_valid;
    tfcr_pkg::t_kind       r_in_kind;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    tfcr_pkg::t_result     r_out;
    logic                  w_adv;
    logic                  w_step;
    logic                  w_hit;
    tfcr_pkg::t_frame_view w_view;
    tfcr_pkg::t_result     w_result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en.slider <= 7'h7F;
            r_en.button <= 8'hFF;
            r_en.key    <= 4'hF;
            r_en.stick  <= 2'h3;
            r_reload    <= tfcr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tfcr_pkg::REG_SLIDER_EN: r_en.slider <= i_cfg_data[6:0];
                tfcr_pkg::REG_BUTTON_EN: r_en.button <= i_cfg_data[7:0];
                tfcr_pkg::REG_KEY_EN:    r_en.key    <= i_cfg_data[3:0];
                tfcr_pkg::REG_STICK_EN:  r_en.stick  <= i_cfg_data[1:0];
                tfcr_pkg::REG_TIMEOUT:   r_reload    <= i_cfg_data;
                default: begin
                    r_reload <= r_reload;
                end
            endcase
        end
    end

    // the work stage moves when the result register is free or being drained
    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind <= tfcr_pkg::t_kind'(i_s_tuser);
            r_in_byte <= i_s_tdata;
        end
    end

    tfcr_rx_state #(
        .OVERRUN_LIMIT (OVERRUN_LIMIT)
    ) u_rx_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .i_reload (r_reload),
        .o_view   (w_view)
    );

    tfcr_decode u_decode (
        .i_view    (w_view),
        .i_enables (r_en),
        .o_hit     (w_hit),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_hit) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.cmd_class;
    assign o_m_tdata  = {4'b0, r_out.value_y, r_out.value_x, r_out.cmd_slot};

    // a tick never yields a command
    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_in_kind == tfcr_pkg::KIND_TICK)) |=> !r_out_valid)
        else $error("tick produced a command");

    // only the joystick class carries a second word
    a_y_only_stick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.cmd_class != tfcr_pkg::CLS_STICK)) |-> (r_out.value_y == '0))
        else $error("value_y set for a non-joystick command");

    // slot zero is never reported
    a_slot_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.cmd_slot != '0))
        else $error("command with slot zero");

    // a stalled result is not overwritten
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending command lost");

endmodule

/* bench/tfcr_command_checker.sv */
// ----------------------------------------------------------------------------
// tfcr_command_checker
// Watches the byte/tick stream, the result stream and the register port of
// the command receiver, predicts every command from its own copy of the
// receive buffer and enables, and compares results in order.
// ----------------------------------------------------------------------------
module tfcr_command_checker
    import tfcr_pkg::*;
#(
    parameter int OVERRUN_LIMIT = OVERRUN_LIMIT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,   // [7:0] rx_byte
    input  logic                   i_s_tuser,   // [0] kind
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // [3:0] cmd_slot, [35:4] value_x, [67:36] value_y, [71:68] zero
    input  logic [M_TDATA_W-1:0]   i_m_tdata,
    input  logic [1:0]             i_m_tuser,   // [1:0] cmd_class
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [7:0]  rx_buf [FRAME_KEEP];
    logic [8:0]  rx_count;
    logic [7:0]  last_byte;
    logic [15:0] idle_left;
    logic [15:0] idle_reload;
    t_enables    slot_en;
    t_result     cmd_q [$];
    int          n_fail;

    initial begin
        n_fail       = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_rx();
        for (int i = 0; i < FRAME_KEEP; i++) rx_buf[i] = 8'h00;
        rx_count  = '0;
        last_byte = '0;
    endfunction

    // header, class, slot and enable checks on the buffer as it stands
    function automatic bit decode_command(output t_result cmd);
        logic [3:0] cls_nib;
        logic [3:0] slot;
        logic [3:0] n_slots;
        logic [7:0] mask;
        t_cmd_class cls;
        cmd = '0;
        if (rx_buf[0] != HEAD_FIRST || rx_buf[1] != HEAD_SECOND) return 1'b0;
        cls_nib = 4'((rx_buf[2] & CLASS_MASK) >> 4);
        slot    = 4'(rx_buf[2] & SLOT_MASK);
        if (cls_nib > 4'd3) return 1'b0;
        cls = t_cmd_class'(cls_nib[1:0]);
        case (cls)
            CLS_SLIDER: begin
                mask = {1'b0, slot_en.slider};
                n_slots = SLIDER_SLOTS;
            end
            CLS_BUTTON: begin
                mask = slot_en.button;
                n_slots = BUTTON_SLOTS;
            end
            CLS_KEY: begin
                mask = {4'b0, slot_en.key};
                n_slots = KEY_SLOTS;
            end
            default: begin
                mask = {6'b0, slot_en.stick};
                n_slots = STICK_SLOTS;
            end
        endcase
        if (slot == 4'd0 || slot > n_slots) return 1'b0;
        if (!mask[slot - 4'd1]) return 1'b0;
        cmd.cmd_class = cls;
        cmd.cmd_slot  = slot;
        cmd.value_x   = {rx_buf[6], rx_buf[5], rx_buf[4], rx_buf[3]};
        cmd.value_y   = (cls == CLS_STICK) ? {rx_buf[10], rx_buf[9], rx_buf[8], rx_buf[7]}
                                           : 32'h0;
        return 1'b1;
    endfunction

    // one byte or tick into the receiver; returns 1 when it yields a command
    function automatic bit advance_receiver(input t_kind kind, input logic [7:0] b,
                                            output t_result cmd);
        bit hit;
        hit = 1'b0;
        cmd = '0;
        if (kind == KIND_TICK) begin
            if (idle_left == 16'd0) clear_rx();
            else idle_left = idle_left - 16'd1;
            return 1'b0;
        end
        if (rx_count < FRAME_KEEP) rx_buf[rx_count] = b;
        rx_count  = rx_count + 9'd1;
        idle_left = idle_reload;
        if (last_byte == TAIL_FIRST && b == TAIL_SECOND) begin
            hit = decode_command(cmd);
            rx_count = '0;
        end
        last_byte = b;
        // overrun is checked after the tail
        if (rx_count > OVERRUN_LIMIT) clear_rx();
        return hit;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result cmd;
        if (!i_rst_n) begin
            clear_rx();
            idle_left   = '0;
            idle_reload = TIMEOUT_RESET;
            slot_en     = '1;
            cmd_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.cmd_class = t_cmd_class'(i_m_tuser);
                got.cmd_slot  = i_m_tdata[3:0];
                got.value_x   = i_m_tdata[35:4];
                got.value_y   = i_m_tdata[67:36];
                if (cmd_q.size() == 0) begin
                    if (n_fail < MAX_REPORTS)
                        $display("%0t: unexpected command class %0d slot %0d x %h y %h",
                                 $time, got.cmd_class, got.cmd_slot, got.value_x,
                                 got.value_y);
                    n_fail++;
                end else begin
                    want = cmd_q.pop_front();
                    if (got.cmd_class !== want.cmd_class || got.cmd_slot !== want.cmd_slot ||
                        got.value_x !== want.value_x || got.value_y !== want.value_y) begin
                        if (n_fail < MAX_REPORTS)
                            $display({"%0t: command mismatch: class exp %0d got %0d, ",
                                      "slot exp %0d got %0d, x exp %h got %h, ",
                                      "y exp %h got %h"},
                                     $time, want.cmd_class, got.cmd_class,
                                     want.cmd_slot, got.cmd_slot, want.value_x,
                                     got.value_x, want.value_y, got.value_y);
                        n_fail++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SLIDER_EN: slot_en.slider = i_cfg_data[6:0];
                    REG_BUTTON_EN: slot_en.button = i_cfg_data[7:0];
                    REG_KEY_EN:    slot_en.key    = i_cfg_data[3:0];
                    REG_STICK_EN:  slot_en.stick  = i_cfg_data[1:0];
                    REG_TIMEOUT:   idle_reload    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (advance_receiver(t_kind'(i_s_tuser), i_s_tdata, cmd))
                    cmd_q.push_back(cmd);
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= cmd_q.size();
    end

endmodule

/* bench/tail_framed_command_receiver_tb.sv */
// ----------------------------------------------------------------------------
// tail_framed_command_receiver_tb
// Drives framed byte streams and timeout ticks into the command receiver,
// first directed frames for each class, drop reason, stale buffer, overrun
// and idle timeout, then random frames and noise over several register
// settings, with random gaps on both streams. A checker predicts and
// compares every command.
// ----------------------------------------------------------------------------
module tail_framed_command_receiver_tb;
    import tfcr_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int IDLE_PCT      = 17;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 8;

    // an index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    bit quiet   = 1'b0;
    int n_sent  = 0;
    int fail_count;
    int pending;

    tail_framed_command_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tfcr_command_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] cmd_byte(input t_cmd_class cls, input int slot);
        return {2'b00, cls, 4'(slot)};
    endfunction

    task automatic send_item(input t_kind kind, input logic [7:0] b);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // fill < 0 gives random payload bytes, otherwise every payload byte is fill
    task automatic send_frame(input logic [7:0] cls_slot, input int n_payload,
                              input int fill, input bit with_head, input bit with_tail,
                              input int tick_pct);
        logic [7:0] b;
        if (with_head) begin
            send_item(KIND_BYTE, HEAD_FIRST);
            send_item(KIND_BYTE, HEAD_SECOND);
        end
        send_item(KIND_BYTE, cls_slot);
        for (int i = 0; i < n_payload; i++) begin
            if ($urandom_range(99) < tick_pct) send_item(KIND_TICK, 8'($urandom));
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            send_item(KIND_BYTE, b);
        end
        if (with_tail) begin
            send_item(KIND_BYTE, TAIL_FIRST);
            send_item(KIND_BYTE, TAIL_SECOND);
        end
    endtask

    // sender holds off until every command is out and the pipe has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_all(input logic [15:0] slider, input logic [15:0] button,
                           input logic [15:0] key, input logic [15:0] stick,
                           input logic [15:0] reload);
        cfg_write(REG_SLIDER_EN, slider);
        cfg_write(REG_BUTTON_EN, button);
        cfg_write(REG_KEY_EN, key);
        cfg_write(REG_STICK_EN, stick);
        cfg_write(REG_TIMEOUT, reload);
    endtask

    task automatic random_burst(input int tick_pct);
        int         r;
        int         len;
        logic [7:0] cls_slot;
        logic [7:0] b;
        r = $urandom_range(99);
        cls_slot = ($urandom_range(9) < 8) ? {2'b00, 2'($urandom), 4'($urandom_range(0, 9))}
                                           : 8'($urandom);
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 10);
        if (r < 75) begin
            send_frame(cls_slot, len, -1, 1'b1, 1'b1, tick_pct);
        end else if (r < 85) begin
            send_frame(cls_slot, len, -1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       tick_pct);
        end else if (r < 95) begin
            // noise leaning on the tail bytes
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(2))
                    0: b = TAIL_FIRST;
                    1: b = TAIL_SECOND;
                    default: b = 8'($urandom);
                endcase
                send_item(KIND_BYTE, b);
            end
        end else begin
            repeat ($urandom_range(1, 8)) send_item(KIND_TICK, 8'($urandom));
        end
    endtask

    initial begin
        int phase_end;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle counter is zero after reset, so this tick clears
        send_item(KIND_TICK, 8'hFF);
        send_frame(cmd_byte(CLS_SLIDER, 1), 4, 8'h00, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_BUTTON, 8), 4, 8'hFF, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_KEY, 4), 4, -1, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_STICK, 2), 8, -1, 1'b1, 1'b1, 0);
        // short joystick frame reports the stale bytes left in the buffer
        send_frame(cmd_byte(CLS_STICK, 1), 2, -1, 1'b1, 1'b1, 0);
        // dropped: class above 3, slot zero, slot beyond its class
        send_frame(8'h41, 4, -1, 1'b1, 1'b1, 0);
        send_frame(8'hFF, 4, -1, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_BUTTON, 0), 4, -1, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_SLIDER, 8), 4, -1, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_KEY, 5), 4, -1, 1'b1, 1'b1, 0);
        send_frame(cmd_byte(CLS_STICK, 3), 8, -1, 1'b1, 1'b1, 0);
        // no header
        send_frame(cmd_byte(CLS_SLIDER, 1), 4, -1, 1'b0, 1'b1, 0);
        // bytes past position 10 are counted only
        send_frame(cmd_byte(CLS_STICK, 1), 25, -1, 1'b1, 1'b1, 0);
        // overrun clears the buffer before the tail shows up
        send_frame(cmd_byte(CLS_BUTTON, 1), OVERRUN_LIMIT_DEF, 8'h55, 1'b1, 1'b0, 0);
        send_item(KIND_BYTE, TAIL_FIRST);
        send_item(KIND_BYTE, TAIL_SECOND);
        // a live tick between the two tail bytes does not break the tail
        send_frame(cmd_byte(CLS_KEY, 1), 4, -1, 1'b1, 1'b0, 0);
        send_item(KIND_BYTE, TAIL_FIRST);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, TAIL_SECOND);

        wait_idle();
        cfg_write(REG_TIMEOUT, 16'd2);
        cfg_write(REG_KEY_EN, 16'd0);
        cfg_write(REG_NONE, 16'hFFFF);
        // disabled slot
        send_frame(cmd_byte(CLS_KEY, 1), 4, -1, 1'b1, 1'b1, 0);
        // two ticks of silence are tolerated, the third clears the buffer
        send_frame(cmd_byte(CLS_BUTTON, 2), 4, -1, 1'b1, 1'b0, 0);
        repeat (2) send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, TAIL_FIRST);
        send_item(KIND_BYTE, TAIL_SECOND);
        send_frame(cmd_byte(CLS_BUTTON, 3), 4, -1, 1'b1, 1'b0, 0);
        repeat (3) send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, TAIL_FIRST);
        send_item(KIND_BYTE, TAIL_SECOND);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: cfg_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           TIMEOUT_RESET);
                3: cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(1, 6)));
                default: cfg_all(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
            endcase
            // one phase runs with no idling on either side
            quiet <= (p == 2);
            phase_end = n_sent + RANDOM_ITEMS / PHASES;
            while (n_sent < phase_end) random_burst((p == 3) ? 15 : 3);
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
